@@ sv/kglf_pkg.sv @@
// Package for the key gesture LED fader: codes, record types and blend helpers.
// Used by kglf_front, kglf_back and key_gesture_led_fader.
`default_nettype none
package kglf_pkg;
    localparam int TIME_BITS_DEF = 48;
    localparam int RAMP_MS = 5000;
    localparam int FADE_MS = 2000;

    // Reciprocals for the blend division: floor(x*R >> s) equals x/den for any
    // magnitude x below 2^21 (ramp: s = 34, fade: s = 33)
    localparam logic [22:0] RECIP_RAMP = 23'd3435974;
    localparam logic [22:0] RECIP_FADE = 23'd4294968;

    localparam logic [1:0] WK_MODE = 2'd0;
    localparam logic [1:0] WK_BRI  = 2'd1;
    localparam logic [1:0] WK_END  = 2'd2;

    localparam logic [1:0] TA_LEAVE = 2'd0;
    localparam logic [1:0] TA_STOP  = 2'd1;
    localparam logic [1:0] TA_REARM = 2'd2;

    localparam logic [1:0] OWN_NONE  = 2'd0;
    localparam logic [1:0] OWN_META  = 2'd1;
    localparam logic [1:0] OWN_ERASE = 2'd2;
    localparam logic [1:0] OWN_ENTER = 2'd3;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_META  = 2'd1;
    localparam logic [1:0] CLS_ERASE = 2'd2;
    localparam logic [1:0] CLS_ENTER = 2'd3;

    localparam logic [1:0] KV_RELEASE = 2'd0;
    localparam logic [1:0] KV_PRESS   = 2'd1;

    localparam logic [1:0] REG_RED = 2'd0;
    localparam logic [1:0] REG_GRN = 2'd1;
    localparam logic [1:0] REG_BLU = 2'd2;
    localparam logic [1:0] REG_BRI = 2'd3;

    // One result word
    typedef struct packed {
        logic [1:0] kind;
        logic       mode;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] bri;
        logic [1:0] timer;
        logic       last;
    } res_t;

    // Scaled delta (b-a)*e, e at most 5000 (13 bits)
    function automatic logic signed [22:0] scale_delta(input logic [7:0] a,
                                                       input logic [7:0] b,
                                                       input logic [12:0] e);
        logic signed [8:0]  d;
        logic signed [13:0] es;
        begin
            d = $signed({1'b0, b}) - $signed({1'b0, a});
            es = $signed({1'b0, e});
            scale_delta = 23'(d * es);
        end
    endfunction
endpackage
`default_nettype wire

@@ sv/key_gesture_led_fader.sv @@
// Top level of the key gesture LED fader: configuration registers and wiring.
// Depends on kglf_pkg, kglf_front, kglf_back.
//
// Input channel: in_valid/in_stall with item_kind, key_class, key_value and
// timestamp_ms. A two-entry queue in the front part takes words while the
// back part is busy. Output channel: out_valid/out_stall, one word per LED
// write followed by an end word with last set (at most seven words).
// In the back part's sequencer an item passes fetch and update, a multiply and
// divide on the release that ends an erase hold, owner selection, and multiply
// and divide when the erase gesture owns the LED, then emits one output word
// per cycle (1 to 7) while out_stall is low. That sequencer sets the throughput:
// it takes no new item until the last word of the current one is accepted.
// Reset clears all gesture state and sets the normal color to white at
// brightness 3. While out_stall is high the current word holds; the queue
// keeps taking input until it is full.
// Configuration is to be written through cfg_we/cfg_index/cfg_data while idle; the block does not enforce this.
`default_nettype none
module key_gesture_led_fader #(
    parameter int TIME_BITS = kglf_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 item_kind,
    input  wire logic [1:0]           key_class,
    input  wire logic [1:0]           key_value,
    input  wire logic [TIME_BITS-1:0] timestamp_ms,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                write_kind,
    output logic                      effect_mode,
    output logic [7:0]                red,
    output logic [7:0]                green,
    output logic [7:0]                blue,
    output logic [7:0]                brightness,
    output logic [1:0]                timer_action,
    output logic                      last
);
    import kglf_pkg::*;

    logic [7:0] nr_reg, ng_reg, nb_reg, nbri_reg;
    logic q_valid, q_pop, q_tick, q_act, q_press;
    logic [1:0] q_cls;
    logic [TIME_BITS-1:0] q_now;
    res_t res;

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nr_reg <= 8'd255; ng_reg <= 8'd255; nb_reg <= 8'd255; nbri_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RED: nr_reg <= cfg_data;
                REG_GRN: ng_reg <= cfg_data;
                REG_BLU: nb_reg <= cfg_data;
                REG_BRI: nbri_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    kglf_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk, .rst_n, .in_valid, .in_stall, .item_kind, .key_class, .key_value,
        .timestamp_ms, .q_valid, .q_pop, .q_tick, .q_act, .q_cls, .q_press, .q_now
    );

    kglf_back #(.TIME_BITS(TIME_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_tick, .q_act, .q_cls, .q_press, .q_now,
        .nr(nr_reg), .ng(ng_reg), .nb(nb_reg), .nbri(nbri_reg),
        .res_valid(out_valid), .res_stall(out_stall), .res(res)
    );

    assign write_kind = res.kind;
    assign effect_mode = res.mode;
    assign red = res.r;
    assign green = res.g;
    assign blue = res.b;
    assign brightness = res.bri;
    assign timer_action = res.timer;
    assign last = res.last;

    // Only the end word closes a run
    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> write_kind == WK_END)
        else $error("last on a non-end word");
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_kind == WK_END |-> last)
        else $error("end word without last");
    a_timer_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_kind != WK_END |-> timer_action == TA_LEAVE)
        else $error("timer action on a write word");
endmodule
`default_nettype wire

@@ sv/kglf_front.sv @@
// Front part: accepts input words, screens them, queues them for the back part.
// Depends on kglf_pkg.
`default_nettype none
module kglf_front #(
    parameter int TIME_BITS = kglf_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 item_kind,
    input  wire logic [1:0]           key_class,
    input  wire logic [1:0]           key_value,
    input  wire logic [TIME_BITS-1:0] timestamp_ms,
    output logic                      q_valid,
    input  wire logic                 q_pop,
    output logic                      q_tick,
    output logic                      q_act,
    output logic [1:0]                q_cls,
    output logic                      q_press,
    output logic [TIME_BITS-1:0]      q_now
);
    import kglf_pkg::*;

    localparam int QW = 5 + TIME_BITS;

    logic [QW-1:0] mem_reg [2];
    logic [1:0]    cnt_reg, cnt_next;
    logic          wp_reg, rp_reg;
    logic          push, act;

    // Classify: only press/release of a known key does any work
    assign act = (key_value == KV_RELEASE || key_value == KV_PRESS) &&
                 key_class != CLS_OTHER;
    assign in_stall = cnt_reg[1];
    assign push = in_valid && !in_stall;
    assign q_valid = cnt_reg != 2'd0;
    assign {q_tick, q_act, q_cls, q_press, q_now} = mem_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(q_pop && q_valid))
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop && q_valid)
            cnt_next = cnt_reg - 2'd1;
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop && q_valid)
                rp_reg <= !rp_reg;
        end
    end

    // Store the classified word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= {item_kind, act, key_class,
                                key_value == KV_PRESS, timestamp_ms};
    end
endmodule
`default_nettype wire

@@ sv/kglf_back.sv @@
// Back part: gesture state, owner selection and emission of LED writes.
// Depends on kglf_pkg.
`default_nettype none
module kglf_back #(
    parameter int TIME_BITS = kglf_pkg::TIME_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_pop,
    input  wire logic                 q_tick,
    input  wire logic                 q_act,
    input  wire logic [1:0]           q_cls,
    input  wire logic                 q_press,
    input  wire logic [TIME_BITS-1:0] q_now,
    input  wire logic [7:0]           nr,
    input  wire logic [7:0]           ng,
    input  wire logic [7:0]           nb,
    input  wire logic [7:0]           nbri,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output kglf_pkg::res_t            res
);
    import kglf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_UPD   = 8'b0000_0010,
        S_OWN   = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_EMIT  = 8'b0010_0000,
        S_REL   = 8'b0100_0000,
        S_RELD  = 8'b1000_0000
    } st_t;

    st_t st_reg, st_next;

    logic [TIME_BITS-1:0] now_reg;
    logic                 tick_reg, act_reg, press_reg;
    logic [1:0]           cls_reg;

    logic [3:0]           meta_held_reg;
    logic [TIME_BITS-1:0] meta_start_reg;
    logic [3:0]           erase_cnt_reg;
    logic                 ramp_held_reg;
    logic [TIME_BITS-1:0] erase_start_reg, fade_start_reg;
    logic                 enter_pend_reg;
    logic [TIME_BITS-1:0] enter_start_reg;
    logic [1:0]           shown_owner_reg;
    logic [TIME_BITS-1:0] shown_since_reg;
    logic [8:0]           shown_bri_reg;
    logic [7:0]           ramp_reg [4];
    logic [7:0]           from_reg [4];
    logic [7:0]           to_reg [4];

    // Emission list
    res_t       list_reg [7];
    logic [2:0] n_reg, idx_reg;
    logic       use_fade_reg, sat_reg;
    logic [12:0] e_reg;
    logic signed [22:0] prod_reg [4];

    // Elapsed times
    logic [TIME_BITS-1:0] d_er, d_fd;
    logic [12:0] e_ramp, e_fade;
    logic fade_on, erase_act;
    assign d_er = (now_reg > erase_start_reg) ? now_reg - erase_start_reg : '0;
    assign d_fd = (now_reg > fade_start_reg) ? now_reg - fade_start_reg : '0;
    assign e_ramp = (d_er >= TIME_BITS'(RAMP_MS)) ? 13'(RAMP_MS) : d_er[12:0];
    assign e_fade = (d_fd >= TIME_BITS'(FADE_MS)) ? 13'(FADE_MS) : d_fd[12:0];
    assign fade_on = fade_start_reg != '0 &&
                     (now_reg < fade_start_reg || d_fd < TIME_BITS'(FADE_MS));
    assign erase_act = ramp_held_reg || fade_on;

    // Owner ignoring/including a pending enter
    logic [1:0] own_base, own_full;
    always_comb
    begin
        own_base = OWN_NONE;
        if (meta_held_reg != 4'd0)
            own_base = OWN_META;
        if (erase_act && (meta_held_reg == 4'd0 || erase_start_reg >= meta_start_reg))
            own_base = OWN_ERASE;
        own_full = own_base;
        if (enter_pend_reg && (own_base == OWN_NONE ||
            (own_base == OWN_META && enter_start_reg >= meta_start_reg) ||
            (own_base == OWN_ERASE && enter_start_reg >= erase_start_reg)))
            own_full = OWN_ENTER;
    end

    // Blend division: (prod +- round)/den truncating toward zero, done as a
    // reciprocal multiply on the magnitude
    function automatic logic [7:0] finish(input logic [7:0] a,
                                          input logic signed [22:0] p,
                                          input logic rnd, input logic fade);
        logic signed [23:0] n;
        logic signed [23:0] half;
        logic [20:0] mag;
        logic [43:0] prd;
        logic [7:0]  q;
        begin
            half = fade ? 24'(FADE_MS / 2) : 24'(RAMP_MS / 2);
            n = 24'(p);
            if (rnd)
                n = (p >= 0) ? n + half : n - half;
            mag = n[23] ? 21'(-n) : n[20:0];
            prd = {23'd0, mag} * {21'd0, (fade ? RECIP_FADE : RECIP_RAMP)};
            q = fade ? prd[40:33] : prd[41:34];
            finish = n[23] ? a - q : a + q;
        end
    endfunction

    function automatic res_t mk(input logic [1:0] k, input logic m,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] br);
        res_t x;
        begin
            x = '0;
            x.kind = k; x.mode = m; x.r = r; x.g = g; x.b = b; x.bri = br;
            mk = x;
        end
    endfunction

    function automatic res_t mk_end(input logic [1:0] ta);
        res_t x;
        begin
            x = '0;
            x.kind = WK_END; x.timer = ta; x.last = 1'b1;
            mk_end = x;
        end
    endfunction

    assign q_pop = (st_reg == S_IDLE);
    assign res_valid = (st_reg == S_EMIT);
    assign res = list_reg[idx_reg];

    logic [7:0] tgt [4];
    logic [7:0] src [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            src[i] = use_fade_reg ? from_reg[i] : ramp_reg[i];
            tgt[i] = use_fade_reg ? to_reg[i] : 8'd0;
        end
        if (!use_fade_reg)
        begin
            tgt[0] = 8'd255;
            tgt[3] = 8'd3;
        end
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (q_valid) st_next = S_UPD;
            S_UPD:   st_next = (!tick_reg && act_reg && cls_reg == CLS_ERASE &&
                                !press_reg && erase_cnt_reg == 4'd1 &&
                                ramp_held_reg) ? S_REL : S_OWN;
            S_REL:   st_next = S_RELD;
            S_RELD:  st_next = S_OWN;
            S_OWN:   st_next = (!tick_reg && !act_reg) ? S_EMIT :
                               (own_base == OWN_ERASE) ? S_MUL : S_EMIT;
            S_MUL:   st_next = S_DIV;
            S_DIV:   st_next = S_EMIT;
            S_EMIT:  if (!res_stall && idx_reg == n_reg - 3'd1) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            meta_held_reg <= '0; meta_start_reg <= '0;
            erase_cnt_reg <= '0; ramp_held_reg <= 1'b0;
            erase_start_reg <= '0; fade_start_reg <= '0;
            enter_pend_reg <= 1'b0; enter_start_reg <= '0;
            shown_owner_reg <= OWN_NONE; shown_since_reg <= '0;
            shown_bri_reg <= 9'd256;
            idx_reg <= '0; n_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                ramp_reg[i] <= '0; from_reg[i] <= '0; to_reg[i] <= '0;
            end
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                S_IDLE:
                begin
                    tick_reg <= q_tick; act_reg <= q_act; cls_reg <= q_cls;
                    press_reg <= q_press; now_reg <= q_now;
                    idx_reg <= '0; n_reg <= '0;
                end
                // Apply the key to the held counts, start times and the pending enter
                S_UPD:
                begin
                    if (!tick_reg && act_reg)
                    begin
                        case (cls_reg)
                            CLS_META:
                                if (press_reg)
                                begin
                                    if (meta_held_reg == 4'd0) meta_start_reg <= now_reg;
                                    if (meta_held_reg != 4'd15)
                                        meta_held_reg <= meta_held_reg + 4'd1;
                                end
                                else if (meta_held_reg != 4'd0)
                                    meta_held_reg <= meta_held_reg - 4'd1;
                            CLS_ERASE:
                                if (press_reg)
                                begin
                                    if (erase_cnt_reg == 4'd0)
                                    begin
                                        erase_start_reg <= now_reg;
                                        ramp_held_reg <= 1'b1;
                                        fade_start_reg <= '0;
                                        ramp_reg[0] <= nr; ramp_reg[1] <= ng;
                                        ramp_reg[2] <= nb; ramp_reg[3] <= nbri;
                                    end
                                    if (erase_cnt_reg != 4'd15)
                                        erase_cnt_reg <= erase_cnt_reg + 4'd1;
                                end
                                else if (erase_cnt_reg != 4'd0)
                                    erase_cnt_reg <= erase_cnt_reg - 4'd1;
                            CLS_ENTER:
                                if (press_reg)
                                begin
                                    enter_pend_reg <= 1'b1;
                                    enter_start_reg <= now_reg;
                                end
                            default: ;
                        endcase
                    end
                    use_fade_reg <= 1'b0;
                    e_reg <= e_ramp;
                end
                // Release of last erase: latch the ramp color as fade origin
                S_REL:
                    for (int i = 0; i < 4; i++)
                        prod_reg[i] <= scale_delta(src[i], tgt[i], e_reg);
                S_RELD:
                begin
                    ramp_held_reg <= 1'b0;
                    fade_start_reg <= now_reg;
                    for (int i = 0; i < 4; i++)
                        from_reg[i] <= finish(src[i], prod_reg[i], i == 3, 1'b0);
                    to_reg[0] <= nr; to_reg[1] <= ng; to_reg[2] <= nb; to_reg[3] <= nbri;
                end
                // Select owner; handle enter flash, none and meta cases
                S_OWN:
                begin
                    if (!tick_reg && !act_reg)
                    begin
                        list_reg[0] <= mk_end(TA_LEAVE);
                        n_reg <= 3'd1;
                    end
                    else
                    begin : own_blk
                        logic [2:0] k;
                        logic [8:0] sb;
                        k = 3'd0;
                        sb = shown_bri_reg;
                        if (own_full == OWN_ENTER)
                        begin
                            list_reg[0] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
                            list_reg[1] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, nbri);
                            list_reg[2] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0);
                            list_reg[3] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, nbri);
                            k = 3'd4;
                            sb = {1'b0, nbri};
                            enter_pend_reg <= 1'b0;
                        end
                        use_fade_reg <= !ramp_held_reg;
                        e_reg <= ramp_held_reg ? e_ramp : e_fade;
                        sat_reg <= ramp_held_reg ? (e_ramp == 13'(RAMP_MS))
                                                 : (e_fade == 13'(FADE_MS));
                        if (own_base == OWN_NONE)
                        begin
                            if (shown_owner_reg != OWN_NONE)
                            begin
                                list_reg[k] <= mk(WK_MODE, 1'b0, nr, ng, nb, 8'd0);
                                list_reg[k+3'd1] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, nbri);
                                k = k + 3'd2;
                                sb = {1'b0, nbri};
                                shown_owner_reg <= OWN_NONE;
                                shown_since_reg <= '0;
                            end
                            list_reg[k] <= mk_end(TA_STOP);
                            k = k + 3'd1;
                        end
                        else if (own_base == OWN_META)
                        begin
                            if (shown_owner_reg != OWN_META ||
                                shown_since_reg != meta_start_reg)
                            begin
                                list_reg[k] <= mk(WK_MODE, 1'b1, nr, ng, nb, 8'd0);
                                k = k + 3'd1;
                                if (sb != {1'b0, nbri})
                                begin
                                    list_reg[k] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, nbri);
                                    k = k + 3'd1;
                                    sb = {1'b0, nbri};
                                end
                                shown_owner_reg <= OWN_META;
                                shown_since_reg <= meta_start_reg;
                            end
                            list_reg[k] <= mk_end(TA_STOP);
                            k = k + 3'd1;
                        end
                        shown_bri_reg <= sb;
                        n_reg <= k;
                    end
                end
                S_MUL:
                    for (int i = 0; i < 4; i++)
                        prod_reg[i] <= scale_delta(src[i], tgt[i], e_reg);
                // Erase owner: color, optional brightness, end word
                S_DIV:
                begin : div_blk
                    logic [7:0] c [4];
                    logic [2:0] k;
                    k = n_reg;
                    for (int i = 0; i < 4; i++)
                        c[i] = sat_reg ? tgt[i]
                               : finish(src[i], prod_reg[i], i == 3, use_fade_reg);
                    list_reg[k] <= mk(WK_MODE, 1'b0, c[0], c[1], c[2], 8'd0);
                    k = k + 3'd1;
                    if (shown_bri_reg != {1'b0, c[3]})
                    begin
                        list_reg[k] <= mk(WK_BRI, 1'b0, 8'd0, 8'd0, 8'd0, c[3]);
                        k = k + 3'd1;
                        shown_bri_reg <= {1'b0, c[3]};
                    end
                    list_reg[k] <= mk_end(sat_reg ? TA_STOP : TA_REARM);
                    n_reg <= k + 3'd1;
                    shown_owner_reg <= OWN_ERASE;
                    shown_since_reg <= erase_start_reg;
                end
                S_EMIT:
                    if (!res_stall)
                        idx_reg <= idx_reg + 3'd1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ tb/key_gesture_led_fader_tb.sv @@
// Self-checking testbench for key_gesture_led_fader: key and tick words in, LED writes out.
// Depends on kglf_pkg and the key_gesture_led_fader RTL. A predictor in this file
// tracks the gesture state and checks every output word.
`default_nettype none
module key_gesture_led_fader_tb;
    import kglf_pkg::*;

    localparam int TB_TIME_BITS = 48;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [1:0] KV_REPEAT = 2'd2;
    localparam logic [1:0] KV_BAD = 2'd3;
    localparam logic [47:0] T_MAX = 48'hFFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = REG_RED;
    logic [7:0] cfg_data = 8'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic item_kind = 1'b0;
    logic [1:0] key_class = CLS_OTHER;
    logic [1:0] key_value = KV_RELEASE;
    logic [47:0] timestamp_ms = 48'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] write_kind;
    logic effect_mode;
    logic [7:0] red, green, blue, brightness;
    logic [1:0] timer_action;
    logic last;

    key_gesture_led_fader #(.TIME_BITS(TB_TIME_BITS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .item_kind(item_kind), .key_class(key_class), .key_value(key_value),
        .timestamp_ms(timestamp_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .write_kind(write_kind), .effect_mode(effect_mode),
        .red(red), .green(green), .blue(blue), .brightness(brightness),
        .timer_action(timer_action), .last(last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predicted LED state
    logic [7:0]  norm [4];
    logic [3:0]  meta_cnt;
    logic [47:0] meta_t0;
    logic [3:0]  erase_cnt;
    logic        ramp_held;
    logic [47:0] erase_t0;
    logic [47:0] fade_t0;
    logic        enter_pend;
    logic [47:0] enter_t0;
    logic [1:0]  shown_own;
    logic [47:0] shown_t0;
    logic [8:0]  shown_bri;
    logic [3:0][7:0] ramp_base, fade_from, fade_to;

    res_t led_writes_q[$];
    int errors = 0;
    int words_seen = 0;
    int items_sent = 0;
    int cycles = 0;
    bit quiet = 1'b0;

    function automatic longint unsigned span(logic [47:0] now, logic [47:0] since,
                                             longint unsigned cap);
        longint unsigned e;
        begin
            e = (now > since) ? longint'(now - since) : 0;
            span = (e > cap) ? cap : e;
        end
    endfunction

    function automatic logic [7:0] mix(int a, int b, longint num, longint den, bit rnd);
        longint n;
        begin
            n = longint'(b - a) * num;
            if (rnd)
                n = (n >= 0) ? n + den / 2 : n - den / 2;
            mix = 8'(longint'(a) + n / den);
        end
    endfunction

    function automatic bit erase_live(logic [47:0] now);
        erase_live = ramp_held ||
            (fade_t0 != 0 && (now < fade_t0 || now - fade_t0 < 48'(FADE_MS)));
    endfunction

    function automatic logic [1:0] gesture_owner(logic [47:0] now);
        logic [1:0] id;
        bit have;
        logic [47:0] best;
        begin
            id = OWN_NONE;
            have = 1'b0;
            best = 0;
            if (meta_cnt > 0)
            begin
                best = meta_t0;
                id = OWN_META;
                have = 1'b1;
            end
            if (erase_live(now) && (!have || erase_t0 >= best))
            begin
                best = erase_t0;
                id = OWN_ERASE;
                have = 1'b1;
            end
            if (enter_pend && (!have || enter_t0 >= best))
                id = OWN_ENTER;
            gesture_owner = id;
        end
    endfunction

    function automatic logic [3:0][7:0] ramp_at(logic [47:0] now);
        longint e;
        logic [3:0][7:0] c;
        begin
            e = longint'(span(now, erase_t0, RAMP_MS));
            c[0] = mix(ramp_base[0], 255, e, RAMP_MS, 1'b0);
            c[1] = mix(ramp_base[1], 0, e, RAMP_MS, 1'b0);
            c[2] = mix(ramp_base[2], 0, e, RAMP_MS, 1'b0);
            c[3] = mix(ramp_base[3], 3, e, RAMP_MS, 1'b1);
            ramp_at = c;
        end
    endfunction

    task automatic emit(logic [1:0] k, logic m, logic [7:0] r, logic [7:0] g,
                        logic [7:0] b, logic [7:0] bri, logic [1:0] ta, logic l);
        res_t w;
        begin
            w.kind = k; w.mode = m; w.r = r; w.g = g; w.b = b;
            w.bri = bri; w.timer = ta; w.last = l;
            led_writes_q.push_back(w);
        end
    endtask

    // Queue the writes that show the current owner
    task automatic show_owner(logic [47:0] now, output logic [1:0] ta);
        logic [1:0] own;
        logic [3:0][7:0] c;
        longint e;
        begin
            own = gesture_owner(now);
            ta = TA_STOP;
            if (own == OWN_ENTER)
            begin
                emit(WK_BRI, 0, 0, 0, 0, 0, TA_LEAVE, 0);
                emit(WK_BRI, 0, 0, 0, 0, norm[3], TA_LEAVE, 0);
                emit(WK_BRI, 0, 0, 0, 0, 0, TA_LEAVE, 0);
                emit(WK_BRI, 0, 0, 0, 0, norm[3], TA_LEAVE, 0);
                shown_bri = {1'b0, norm[3]};
                enter_pend = 1'b0;
                own = gesture_owner(now);
            end
            if (own == OWN_NONE)
            begin
                if (shown_own != OWN_NONE)
                begin
                    emit(WK_MODE, 0, norm[0], norm[1], norm[2], 0, TA_LEAVE, 0);
                    emit(WK_BRI, 0, 0, 0, 0, norm[3], TA_LEAVE, 0);
                    shown_bri = {1'b0, norm[3]};
                    shown_own = OWN_NONE;
                    shown_t0 = 0;
                end
            end
            else if (own == OWN_META)
            begin
                if (shown_own != OWN_META || shown_t0 != meta_t0)
                begin
                    emit(WK_MODE, 1, norm[0], norm[1], norm[2], 0, TA_LEAVE, 0);
                    if (shown_bri != {1'b0, norm[3]})
                    begin
                        emit(WK_BRI, 0, 0, 0, 0, norm[3], TA_LEAVE, 0);
                        shown_bri = {1'b0, norm[3]};
                    end
                    shown_own = OWN_META;
                    shown_t0 = meta_t0;
                end
            end
            else
            begin
                if (ramp_held)
                begin
                    if (span(now, erase_t0, RAMP_MS) >= RAMP_MS)
                        c = {8'd3, 8'd0, 8'd0, 8'd255};
                    else
                    begin
                        c = ramp_at(now);
                        ta = TA_REARM;
                    end
                end
                else
                begin
                    e = longint'(span(now, fade_t0, FADE_MS));
                    if (e >= FADE_MS)
                        c = fade_to;
                    else
                    begin
                        for (int i = 0; i < 4; i++)
                            c[i] = mix(fade_from[i], fade_to[i], e, FADE_MS, i == 3);
                        ta = TA_REARM;
                    end
                end
                emit(WK_MODE, 0, c[0], c[1], c[2], 0, TA_LEAVE, 0);
                if (shown_bri != {1'b0, c[3]})
                begin
                    emit(WK_BRI, 0, 0, 0, 0, c[3], TA_LEAVE, 0);
                    shown_bri = {1'b0, c[3]};
                end
                shown_own = OWN_ERASE;
                shown_t0 = erase_t0;
            end
        end
    endtask

    // Advance the gesture state by one accepted word and queue its writes
    task automatic predict_led_writes(logic k, logic [1:0] cls, logic [1:0] val,
                                      logic [47:0] now);
        logic [1:0] ta;
        begin
            ta = TA_LEAVE;
            if (k)
                show_owner(now, ta);
            else if (val <= KV_PRESS && cls != CLS_OTHER)
            begin
                if (cls == CLS_META)
                begin
                    if (val == KV_PRESS)
                    begin
                        if (meta_cnt == 0)
                            meta_t0 = now;
                        if (meta_cnt < 15)
                            meta_cnt++;
                    end
                    else if (meta_cnt > 0)
                        meta_cnt--;
                end
                else if (cls == CLS_ERASE)
                begin
                    if (val == KV_PRESS)
                    begin
                        if (erase_cnt == 0)
                        begin
                            erase_t0 = now;
                            ramp_held = 1'b1;
                            fade_t0 = 0;
                            ramp_base = {norm[3], norm[2], norm[1], norm[0]};
                        end
                        if (erase_cnt < 15)
                            erase_cnt++;
                    end
                    else if (erase_cnt > 0)
                    begin
                        erase_cnt--;
                        if (erase_cnt == 0 && ramp_held)
                        begin
                            ramp_held = 1'b0;
                            fade_t0 = now;
                            fade_from = ramp_at(now);
                            fade_to = {norm[3], norm[2], norm[1], norm[0]};
                        end
                    end
                end
                else if (val == KV_PRESS)
                begin
                    enter_pend = 1'b1;
                    enter_t0 = now;
                end
                show_owner(now, ta);
            end
            emit(WK_END, 0, 0, 0, 0, 0, ta, 1);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Check accepted words and drive the output stall
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            words_seen++;
            if (led_writes_q.size() == 0)
                report_mismatch("unexpected word, kind", write_kind, -1);
            else
            begin
                res_t w;
                w = led_writes_q.pop_front();
                if (write_kind !== w.kind) report_mismatch("write_kind", write_kind, w.kind);
                if (effect_mode !== w.mode) report_mismatch("effect_mode", effect_mode, w.mode);
                if (red !== w.r) report_mismatch("red", red, w.r);
                if (green !== w.g) report_mismatch("green", green, w.g);
                if (blue !== w.b) report_mismatch("blue", blue, w.b);
                if (brightness !== w.bri) report_mismatch("brightness", brightness, w.bri);
                if (timer_action !== w.timer)
                    report_mismatch("timer_action", timer_action, w.timer);
                if (last !== w.last) report_mismatch("last", last, w.last);
            end
        end
        out_stall <= !quiet && ($urandom_range(0, 99) < 7);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("key_gesture_led_fader_tb: FAIL");
            $finish;
        end
    end

    // Send one word; on acceptance the predictor runs. A typed end timer
    // replaces the predicted words when given. Valid stays high after
    // acceptance until the next word or an explicit idle.
    task automatic send_word(logic k, logic [1:0] cls, logic [1:0] val, logic [47:0] t,
                             bit typed, logic [1:0] want_ta);
        int queued;
        begin
            if (!quiet && $urandom_range(0, 99) < 7)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            in_valid <= 1'b1;
            item_kind <= k;
            key_class <= cls;
            key_value <= val;
            timestamp_ms <= t;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            queued = led_writes_q.size();
            predict_led_writes(k, cls, val, t);
            if (typed)
            begin
                while (led_writes_q.size() > queued)
                    void'(led_writes_q.pop_back());
                emit(WK_END, 0, 0, 0, 0, 0, want_ta, 1);
            end
            items_sent++;
        end
    endtask

    // Drain, then write all four color registers
    task automatic set_normal(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] bri);
        logic [1:0] idx [4];
        logic [7:0] val [4];
        begin
            idx = '{REG_RED, REG_GRN, REG_BLU, REG_BRI};
            val = '{r, g, b, bri};
            in_valid <= 1'b0;
            while (led_writes_q.size() != 0)
                @(posedge clk);
            repeat (16) @(posedge clk);
            for (int i = 0; i < 4; i++)
            begin
                cfg_we <= 1'b1;
                cfg_index <= idx[i];
                cfg_data <= val[i];
                norm[idx[i]] = val[i];
                @(posedge clk);
            end
            cfg_we <= 1'b0;
        end
    endtask

    // Random gesture traffic around a moving clock
    task automatic random_words(int count);
        logic [47:0] now;
        logic [1:0] cls, val;
        int burst;
        begin
            now = 48'd1000 + $urandom_range(0, 5000);
            for (int n = 0; n < count; n++)
            begin
                quiet = (n >= 15 && n < 30);
                if ($urandom_range(0, 99) < 2)
                    now = {16'($urandom), 32'($urandom)};
                else if ($urandom_range(0, 99) < 4)
                    now = now - $urandom_range(0, 300);
                else
                    now = now + $urandom_range(0, 700);
                if ($urandom_range(0, 99) < 3)
                begin
                    // Press one key past the count limit, then let it all go
                    cls = $urandom_range(0, 1) ? CLS_META : CLS_ERASE;
                    for (burst = 0; burst < 17; burst++)
                        send_word(0, cls, KV_PRESS, now + burst, 0, TA_LEAVE);
                    for (burst = 0; burst < 17; burst++)
                        send_word(0, cls, KV_RELEASE, now + 20 + burst, 0, TA_LEAVE);
                    now = now + 40;
                    n = n + 33;
                end
                else if ($urandom_range(0, 99) < 35)
                    send_word(1, 2'($urandom), 2'($urandom), now, 0, TA_LEAVE);
                else
                begin
                    cls = ($urandom_range(0, 99) < 8) ? CLS_OTHER : 2'($urandom_range(1, 3));
                    val = ($urandom_range(0, 99) < 8) ? 2'($urandom_range(2, 3))
                                                      : 2'($urandom_range(0, 1));
                    send_word(0, cls, val, now, 0, TA_LEAVE);
                end
            end
            quiet = 1'b0;
        end
    endtask

    typedef struct {
        logic k;
        logic [1:0] cls;
        logic [1:0] val;
        logic [47:0] t;
        bit typed;
        logic [1:0] ta;
    } row_t;

    row_t plan [$];

    initial
    begin
        norm = '{8'd255, 8'd255, 8'd255, 8'd3};
        meta_cnt = 0; meta_t0 = 0; erase_cnt = 0; ramp_held = 0; erase_t0 = 0;
        fade_t0 = 0; enter_pend = 0; enter_t0 = 0; shown_own = OWN_NONE; shown_t0 = 0;
        shown_bri = 9'd256; ramp_base = '0; fade_from = '0; fade_to = '0;

        plan = '{
            '{1, CLS_OTHER, KV_RELEASE, 48'd0,     1, TA_STOP},  // tick, nothing held
            '{0, CLS_OTHER, KV_PRESS,   48'd10,    1, TA_LEAVE}, // other key
            '{0, CLS_META,  KV_REPEAT,  48'd15,    1, TA_LEAVE}, // autorepeat
            '{0, CLS_ERASE, KV_BAD,     48'd16,    1, TA_LEAVE}, // invalid value
            '{0, CLS_META,  KV_RELEASE, 48'd20,    0, TA_LEAVE}, // release with none held
            '{0, CLS_META,  KV_PRESS,   48'd30,    0, TA_LEAVE},
            '{1, CLS_META,  KV_RELEASE, 48'd80,    0, TA_LEAVE},
            '{0, CLS_META,  KV_RELEASE, 48'd100,   0, TA_LEAVE},
            '{0, CLS_ERASE, KV_PRESS,   48'd200,   0, TA_LEAVE},
            '{1, CLS_OTHER, KV_RELEASE, 48'd2700,  0, TA_LEAVE},
            '{1, CLS_OTHER, KV_RELEASE, 48'd5200,  0, TA_LEAVE},
            '{1, CLS_OTHER, KV_RELEASE, 48'd9000,  0, TA_LEAVE},
            '{0, CLS_ERASE, KV_RELEASE, 48'd4100,  0, TA_LEAVE}, // time going back
            '{1, CLS_OTHER, KV_RELEASE, 48'd5100,  0, TA_LEAVE},
            '{1, CLS_OTHER, KV_RELEASE, 48'd7000,  0, TA_LEAVE},
            '{0, CLS_ENTER, KV_PRESS,   48'd7100,  0, TA_LEAVE},
            '{0, CLS_ENTER, KV_RELEASE, 48'd7200,  0, TA_LEAVE},
            '{0, CLS_ERASE, KV_PRESS,   48'd0,     0, TA_LEAVE}, // release at time zero
            '{0, CLS_ERASE, KV_RELEASE, 48'd0,     0, TA_LEAVE},
            '{1, CLS_OTHER, KV_RELEASE, 48'd5,     0, TA_LEAVE},
            '{0, CLS_META,  KV_PRESS,   T_MAX,     0, TA_LEAVE},
            '{0, CLS_ENTER, KV_PRESS,   T_MAX,     0, TA_LEAVE}, // tie, enter wins
            '{1, CLS_ENTER, KV_PRESS,   T_MAX,     0, TA_LEAVE},
            '{0, CLS_META,  KV_RELEASE, 48'd0,     0, TA_LEAVE}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_word(plan[i].k, plan[i].cls, plan[i].val, plan[i].t, plan[i].typed,
                      plan[i].ta);
        random_words(35);

        set_normal(8'd0, 8'd0, 8'd0, 8'd0);
        random_words(40);
        set_normal(8'd255, 8'd255, 8'd255, 8'd255);
        random_words(40);
        set_normal(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        random_words(40);

        in_valid <= 1'b0;
        while (led_writes_q.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("sent %0d key and tick words over four color settings, checked %0d LED words",
                 items_sent, words_seen);
        if (errors == 0 && led_writes_q.size() == 0)
            $display("key_gesture_led_fader_tb: PASS");
        else
            $display("key_gesture_led_fader_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
